@@ design/erlt_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// erlt_pkg
// Shared types and codes for the exclusive record lock table.
// ----------------------------------------------------------------------------
package erlt_pkg;

	localparam int OP_W      = 2;
	localparam int REC_W     = 32;
	localparam int TXN_W     = 16;
	localparam int STATUS_W  = 3;

	// operation codes
	localparam logic [OP_W-1:0] OP_LOCK       = 2'd0;
	localparam logic [OP_W-1:0] OP_UNLOCK     = 2'd1;
	localparam logic [OP_W-1:0] OP_UNLOCK_ALL = 2'd2;

	// status codes
	localparam logic [STATUS_W-1:0] STATUS_GRANTED  = 3'd0;
	localparam logic [STATUS_W-1:0] STATUS_HELD     = 3'd1;
	localparam logic [STATUS_W-1:0] STATUS_CONFLICT = 3'd2;
	localparam logic [STATUS_W-1:0] STATUS_FULL     = 3'd3;
	localparam logic [STATUS_W-1:0] STATUS_RELEASED = 3'd4;

	typedef enum logic [1:0] {
		S_CLEAR,
		S_IDLE,
		S_SCAN,
		S_FINISH
	} lock_state_t;

	typedef struct packed {
		logic [OP_W-1:0]  operation;
		logic [REC_W-1:0] record_id;
		logic [TXN_W-1:0] transaction;
	} lock_req_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [TXN_W-1:0]    blocker;
	} lock_rsp_t;

endpackage

@@ design/erlt_table_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// erlt_table_ram
// Lock entry storage: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module erlt_table_ram #(
	parameter int DEPTH  = 64,
	parameter int DATA_W = 49,
	parameter int ADDR_W = 6
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [DEPTH];
	logic [DATA_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ design/exclusive_record_lock_table.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// exclusive_record_lock_table
// Table of exclusive record locks, searched one entry per cycle.
// ----------------------------------------------------------------------------
// Each accepted start reads every entry through the single read port of the
// entry memory, one entry per cycle through one compare unit; a finish step
// then writes any grant and registers done; no request is taken before it ends.
// Reset: after arst_n releases, busy stays high while the valid marks in
// memory are cleared one entry per cycle.
// Results are shown for one cycle on done; the receiver cannot stall.
module exclusive_record_lock_table
	import erlt_pkg::*;
#(
	parameter int ENTRIES     = 64,
	parameter int RECORD_BITS = 32,
	parameter int TXN_BITS    = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	output logic      busy,
	input  lock_req_t req,
	output logic      done,
	output lock_rsp_t rsp
);

	localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CNT_W = $clog2(ENTRIES + 1);
	localparam int ENT_W = 1 + RECORD_BITS + TXN_BITS;

	lock_state_t state_q, state_d;

	logic [CNT_W-1:0]       issue_q;
	logic                   rd_vld_s1;
	logic [IDX_W-1:0]       rd_idx_s1;

	logic [OP_W-1:0]        op_q;
	logic [RECORD_BITS-1:0] key_rec_q;
	logic [TXN_BITS-1:0]    key_txn_q;

	logic                   hit_q;
	logic                   hit_own_q;
	logic [TXN_BITS-1:0]    hit_owner_q;
	logic                   free_found_q;
	logic [IDX_W-1:0]       free_idx_q;

	logic                   done_q;
	lock_rsp_t              rsp_q;

	logic                   accept;
	logic                   rd_en;
	logic                   we;
	logic [IDX_W-1:0]       waddr;
	logic [ENT_W-1:0]       wdata;
	logic [ENT_W-1:0]       rd_data;

	logic                   ent_valid;
	logic [RECORD_BITS-1:0] ent_rec;
	logic [TXN_BITS-1:0]    ent_own;
	logic                   rec_match;
	logic                   own_match;
	logic                   drop_entry;
	lock_rsp_t              rsp_d;

	assign accept = start && (state_q == S_IDLE);
	assign busy   = (state_q != S_IDLE);

	// compare unit, one entry per cycle
	assign ent_valid = rd_data[ENT_W-1];
	assign ent_rec   = rd_data[RECORD_BITS+TXN_BITS-1:TXN_BITS];
	assign ent_own   = rd_data[TXN_BITS-1:0];
	assign rec_match = ent_valid && (ent_rec == key_rec_q);
	assign own_match = (ent_own == key_txn_q);

	always_comb begin
		drop_entry = 1'b0;
		if (rd_vld_s1) begin
			case (op_q)
				OP_UNLOCK:     drop_entry = rec_match && own_match;
				OP_UNLOCK_ALL: drop_entry = ent_valid && own_match;
				default:       drop_entry = 1'b0;
			endcase
		end
	end

	always_comb begin
		rsp_d.status  = STATUS_RELEASED;
		rsp_d.blocker = '0;
		case (op_q)
			OP_LOCK: begin
				if (hit_q) begin
					if (hit_own_q) begin
						rsp_d.status = STATUS_HELD;
					end else begin
						rsp_d.status  = STATUS_CONFLICT;
						rsp_d.blocker = TXN_W'(hit_owner_q);
					end
				end else if (free_found_q) begin
					rsp_d.status = STATUS_GRANTED;
				end else begin
					rsp_d.status = STATUS_FULL;
				end
			end
			default: rsp_d.status = STATUS_RELEASED;
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_CLEAR: begin
				if (issue_q == CNT_W'(ENTRIES - 1)) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (start) begin
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				if (issue_q == CNT_W'(ENTRIES)) begin
					state_d = S_FINISH;
				end
			end
			S_FINISH: state_d = S_IDLE;
			default:  state_d = S_IDLE;
		endcase
	end

	// memory port control
	always_comb begin
		rd_en = 1'b0;
		we    = 1'b0;
		waddr = issue_q[IDX_W-1:0];
		wdata = '0;
		case (state_q)
			S_CLEAR: begin
				we = 1'b1;
			end
			S_SCAN: begin
				rd_en = (issue_q != CNT_W'(ENTRIES));
				we    = drop_entry;
				waddr = rd_idx_s1;
			end
			S_FINISH: begin
				we    = (op_q == OP_LOCK) && !hit_q && free_found_q;
				waddr = free_idx_q;
				wdata = {1'b1, key_rec_q, key_txn_q};
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLEAR;
			issue_q   <= '0;
			rd_vld_s1 <= 1'b0;
			done_q    <= 1'b0;
		end else begin
			state_q   <= state_d;
			rd_vld_s1 <= rd_en;
			done_q    <= (state_q == S_FINISH);
			case (state_q)
				S_CLEAR: issue_q <= issue_q + CNT_W'(1);
				S_IDLE:  issue_q <= '0;
				S_SCAN: begin
					if (rd_en) begin
						issue_q <= issue_q + CNT_W'(1);
					end
				end
				default: issue_q <= issue_q;
			endcase
		end
	end

	// request fields, scan bookkeeping and result payload
	always_ff @(posedge clk) begin
		rd_idx_s1 <= issue_q[IDX_W-1:0];
		if (accept) begin
			op_q         <= req.operation;
			key_rec_q    <= RECORD_BITS'(req.record_id);
			key_txn_q    <= TXN_BITS'(req.transaction);
			hit_q        <= 1'b0;
			free_found_q <= 1'b0;
		end else if (rd_vld_s1) begin
			if (rec_match) begin
				hit_q       <= 1'b1;
				hit_own_q   <= own_match;
				hit_owner_q <= ent_own;
			end
			// lowest free index wins
			if (!ent_valid && !free_found_q) begin
				free_found_q <= 1'b1;
				free_idx_q   <= rd_idx_s1;
			end
		end
		if (state_q == S_FINISH) begin
			rsp_q <= rsp_d;
		end
	end

	erlt_table_ram #(
		.DEPTH  (ENTRIES),
		.DATA_W (ENT_W),
		.ADDR_W (IDX_W)
	) u_table (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (rd_en),
		.raddr (issue_q[IDX_W-1:0]),
		.rdata (rd_data)
	);

	assign done = done_q;
	assign rsp  = rsp_q;

endmodule

@@ tb/exclusive_record_lock_table_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// exclusive_record_lock_table_tb
// Drives lock, unlock, unlock-all and reserved requests into the lock table, keeps its
// own copy of the table to work out each status and blocker, and compares
// every done strobe against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module exclusive_record_lock_table_tb;
	import erlt_pkg::*;

	localparam int TABLE_ENTRIES = 64;
	localparam int RANDOM_ITEMS  = 1650;
	localparam int REC_POOL      = 96;
	localparam int TXN_POOL      = 8;
	// operation code the block must treat as a no-op
	localparam logic [OP_W-1:0] OP_RESERVED = 2'd3;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      start = 1'b0;
	logic      busy;
	lock_req_t req = '0;
	logic      done;
	lock_rsp_t rsp;

	lock_req_t pending_requests[$];
	lock_rsp_t lock_outcomes[$];
	lock_req_t granted_history[$];

	// predicted table contents
	logic             held_valid[TABLE_ENTRIES];
	logic [REC_W-1:0] held_record[TABLE_ENTRIES];
	logic [TXN_W-1:0] held_owner[TABLE_ENTRIES];

	logic [REC_W-1:0] rec_pool[REC_POOL];
	logic [TXN_W-1:0] txn_pool[TXN_POOL];

	int mismatch_count = 0;
	int idle_left = 0;
	int burst_left = 0;
	logic gap_on_idle = 1'b0;

	exclusive_record_lock_table #(
		.ENTRIES(TABLE_ENTRIES),
		.RECORD_BITS(REC_W),
		.TXN_BITS(TXN_W)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req(req),
		.done(done),
		.rsp(rsp)
	);

	always #10 clk = ~clk;

	function automatic lock_rsp_t predict_lock(lock_req_t r);
		lock_rsp_t res;
		int hit;
		int i;
		logic placed;
		res.status = STATUS_RELEASED;
		res.blocker = '0;
		hit = -1;
		placed = 1'b0;
		for (i = 0; i < TABLE_ENTRIES; i++)
			if (hit < 0 && held_valid[i] && held_record[i] == r.record_id)
				hit = i;
		case (r.operation)
			OP_LOCK: begin
				if (hit >= 0) begin
					if (held_owner[hit] == r.transaction) begin
						res.status = STATUS_HELD;
					end else begin
						res.status = STATUS_CONFLICT;
						res.blocker = held_owner[hit];
					end
				end else begin
					res.status = STATUS_FULL;
					// lowest free entry wins
					for (i = 0; i < TABLE_ENTRIES; i++) begin
						if (!placed && !held_valid[i]) begin
							held_valid[i] = 1'b1;
							held_record[i] = r.record_id;
							held_owner[i] = r.transaction;
							res.status = STATUS_GRANTED;
							placed = 1'b1;
						end
					end
				end
			end
			OP_UNLOCK: begin
				if (hit >= 0 && held_owner[hit] == r.transaction)
					held_valid[hit] = 1'b0;
			end
			OP_UNLOCK_ALL: begin
				for (i = 0; i < TABLE_ENTRIES; i++)
					if (held_valid[i] && held_owner[i] == r.transaction)
						held_valid[i] = 1'b0;
			end
			default: ;
		endcase
		return res;
	endfunction

	function automatic int draw_gap();
		if (burst_left > 0) begin
			burst_left--;
			return 0;
		end
		if ($urandom_range(0, 19) == 0) begin
			burst_left = $urandom_range(4, 24);
			return 0;
		end
		return $urandom_range(0, 14);
	endfunction

	function automatic logic [REC_W-1:0] pick_record();
		if ($urandom_range(0, 9) == 0)
			return $urandom();
		return rec_pool[$urandom_range(0, REC_POOL - 1)];
	endfunction

	function automatic logic [TXN_W-1:0] pick_txn();
		if ($urandom_range(0, 9) == 0)
			return TXN_W'($urandom_range(0, 16'hFFFF));
		return txn_pool[$urandom_range(0, TXN_POOL - 1)];
	endfunction

	task automatic add_request(logic [OP_W-1:0] op, logic [REC_W-1:0] rec,
			logic [TXN_W-1:0] txn);
		lock_req_t r;
		r.operation = op;
		r.record_id = rec;
		r.transaction = txn;
		pending_requests.push_back(r);
		if (op == OP_LOCK) begin
			granted_history.push_back(r);
			if (granted_history.size() > TABLE_ENTRIES)
				void'(granted_history.pop_front());
		end
	endtask

	// request driver
	always @(posedge clk) begin
		logic took;
		logic nxt_start;
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			took = start && !busy;
			nxt_start = start && !took;
			if (took) begin
				lock_outcomes.push_back(predict_lock(req));
				idle_left = draw_gap();
				gap_on_idle = ($urandom_range(0, 2) != 0);
			end
			if (!nxt_start && pending_requests.size() > 0) begin
				if (idle_left == 0) begin
					req <= pending_requests.pop_front();
					nxt_start = 1'b1;
				end else if (!gap_on_idle || !busy) begin
					// some gaps run out while the block works, others only once idle
					idle_left--;
				end
			end
			start <= nxt_start;
		end
	end

	// result monitor
	always @(posedge clk) begin
		lock_rsp_t want;
		if (arst_n && done) begin
			if (lock_outcomes.size() == 0) begin
				$error("result with no request outstanding: status %0d blocker %0h",
					rsp.status, rsp.blocker);
				mismatch_count++;
			end else begin
				want = lock_outcomes.pop_front();
				if (rsp.status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, rsp.status);
					mismatch_count++;
				end
				if (rsp.blocker !== want.blocker) begin
					$error("blocker: expected %0h, got %0h", want.blocker, rsp.blocker);
					mismatch_count++;
				end
			end
		end
	end

	initial begin
		#20_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	initial begin
		int n;
		int k;
		int pick;
		lock_req_t h;
		logic [TXN_W-1:0] t;

		for (k = 0; k < TABLE_ENTRIES; k++) begin
			held_valid[k] = 1'b0;
			held_record[k] = '0;
			held_owner[k] = '0;
		end
		rec_pool[0] = '0;
		rec_pool[1] = '1;
		rec_pool[2] = 32'h8000_0000;
		rec_pool[3] = 32'h0000_0001;
		for (k = 4; k < REC_POOL; k++)
			rec_pool[k] = $urandom();
		txn_pool[0] = '0;
		txn_pool[1] = '1;
		txn_pool[2] = 16'h8000;
		txn_pool[3] = 16'h0001;
		for (k = 4; k < TXN_POOL; k++)
			txn_pool[k] = TXN_W'($urandom_range(0, 16'hFFFF));

		// directed: grant, regrant, conflict, releases and the no-op cases
		add_request(OP_LOCK, '0, '0);
		add_request(OP_LOCK, '0, '0);
		add_request(OP_LOCK, '1, '1);
		add_request(OP_LOCK, '1, 16'h0001);
		add_request(OP_LOCK, '0, '1);
		add_request(OP_UNLOCK, '1, 16'h0001);
		add_request(OP_LOCK, '1, 16'h0001);
		add_request(OP_UNLOCK, 32'h1234_5678, '1);
		add_request(OP_UNLOCK, '1, '1);
		add_request(OP_LOCK, '1, 16'h0001);
		add_request(OP_RESERVED, '1, '1);
		add_request(OP_RESERVED, '0, '0);
		add_request(OP_UNLOCK_ALL, '0, 16'h0007);
		add_request(OP_LOCK, 32'h8000_0000, '0);
		add_request(OP_UNLOCK_ALL, 32'hDEAD_BEEF, '0);
		add_request(OP_LOCK, '0, 16'h8000);
		add_request(OP_LOCK, 32'h8000_0000, 16'h8000);
		add_request(OP_UNLOCK_ALL, '1, 16'h8000);
		add_request(OP_UNLOCK, '1, 16'h0001);
		add_request(OP_LOCK, '1, 16'h7FFF);
		add_request(OP_UNLOCK_ALL, '0, 16'h7FFF);

		n = 0;
		while (n < RANDOM_ITEMS) begin
			if (n == 400 || $urandom_range(0, 299) == 0) begin
				// fill the table past capacity, then drain it owner by owner
				for (k = 0; k < 72; k++)
					add_request(OP_LOCK, $urandom(), txn_pool[$urandom_range(0, 3)]);
				for (k = 0; k < TXN_POOL; k++)
					add_request(OP_UNLOCK_ALL, $urandom(), txn_pool[k]);
				n += 72 + TXN_POOL;
			end else begin
				pick = $urandom_range(0, 99);
				if (pick < 45) begin
					add_request(OP_LOCK, pick_record(), pick_txn());
				end else if (pick < 72) begin
					if (granted_history.size() > 0 && $urandom_range(0, 4) != 0) begin
						h = granted_history[$urandom_range(0, granted_history.size() - 1)];
						add_request(OP_UNLOCK, h.record_id, h.transaction);
					end else begin
						add_request(OP_UNLOCK, pick_record(), pick_txn());
					end
				end else if (pick < 80) begin
					t = pick_txn();
					add_request(OP_UNLOCK_ALL, $urandom(), t);
				end else if (pick < 85) begin
					add_request(OP_RESERVED, $urandom(),
						TXN_W'($urandom_range(0, 16'hFFFF)));
				end else begin
					// relock attempts by another owner or the same one
					if (granted_history.size() > 0) begin
						h = granted_history[$urandom_range(0, granted_history.size() - 1)];
						t = ($urandom_range(0, 1) != 0) ? h.transaction : pick_txn();
						add_request(OP_LOCK, h.record_id, t);
					end else begin
						add_request(OP_LOCK, pick_record(), pick_txn());
					end
				end
				n++;
			end
		end

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		do
			@(posedge clk);
		while (!(pending_requests.size() == 0 && !start && lock_outcomes.size() == 0));
		repeat (80) @(posedge clk);

		if (mismatch_count == 0 && lock_outcomes.size() == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
